// ----- sv/svw_pkg.sv -----
// ----------------------------------------------------------------------------
// svw_pkg
// Shared types and constants of the SPI display window writer.
// ----------------------------------------------------------------------------
package svw_pkg;

  localparam int ADDR_W  = 18;
  localparam int PIXEL_W = 16;
  localparam int BYTE_W  = 8;
  localparam int WORD_W  = 16;

  // Pin event codes
  localparam logic [1:0] OP_CLK_FALL = 2'd0;
  localparam logic [1:0] OP_CS_RISE  = 2'd1;
  localparam logic [1:0] OP_DC_FALL  = 2'd2;

  // Display commands
  localparam logic [BYTE_W-1:0] CMD_COLUMN_SET   = 8'h2A;
  localparam logic [BYTE_W-1:0] CMD_ROW_SET      = 8'h2B;
  localparam logic [BYTE_W-1:0] CMD_MEMORY_WRITE = 8'h2C;

  localparam logic [WORD_W-1:0] Y_LIMIT = 16'hFFFF;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    EV_NONE,
    EV_BYTE,
    EV_ACT
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t          kind;
    logic [BYTE_W-1:0] data;
    logic              dc;
  } pin_event_t;

  typedef struct packed {
    logic       push;
    pin_event_t ev;
  } queue_push_t;

  typedef struct packed {
    logic       valid;
    pin_event_t ev;
  } queue_head_t;

endpackage

// ----- sv/svw_if.sv -----
// ----------------------------------------------------------------------------
// svw_if
// Valid/ready channels of the SPI display window writer.
// ----------------------------------------------------------------------------
interface svw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic       mosi_bit;
  logic       dc_level;
  logic       cs_level;

  modport source (output valid, output operation, output mosi_bit, output dc_level,
                  output cs_level, input ready);
  modport sink   (input valid, input operation, input mosi_bit, input dc_level,
                  input cs_level, output ready);
endinterface

interface svw_out_if;
  logic                        valid;
  logic                        ready;
  logic                        write_enable;
  logic [svw_pkg::ADDR_W-1:0]  write_address;
  logic [svw_pkg::PIXEL_W-1:0] pixel_value;
  logic                        frame_ready;

  modport source (output valid, output write_enable, output write_address,
                  output pixel_value, output frame_ready, input ready);
  modport sink   (input valid, input write_enable, input write_address,
                  input pixel_value, input frame_ready, output ready);
endinterface

// ----- sv/svw_front.sv -----
// ----------------------------------------------------------------------------
// svw_front
// Accepts pin events, assembles serial bytes and classifies each event.
// ----------------------------------------------------------------------------
module svw_front (
  input  logic                 clk,
  input  logic                 rst,
  svw_in_if.sink               pin,
  input  logic                 queue_full,
  output svw_pkg::queue_push_t push
);
  import svw_pkg::*;

  logic [BYTE_W-1:0] shift_byte, shift_byte_next;
  logic [2:0]        bit_count, bit_count_next;
  logic              accept;

  assign pin.ready = !queue_full;
  assign accept    = pin.valid && pin.ready;

  always_comb begin
    shift_byte_next = shift_byte;
    bit_count_next  = bit_count;
    push.push       = accept;
    push.ev.kind    = EV_NONE;
    push.ev.dc      = pin.dc_level;
    push.ev.data    = {shift_byte[BYTE_W-2:0], pin.mosi_bit};
    if (accept) begin
      unique case (pin.operation)
        OP_CLK_FALL: begin
          if (!pin.cs_level) begin
            shift_byte_next = {shift_byte[BYTE_W-2:0], pin.mosi_bit};
            bit_count_next  = bit_count + 3'd1;
            // eighth bit completes the byte
            if (bit_count == 3'd7) begin
              push.ev.kind = EV_BYTE;
            end
          end
        end
        OP_CS_RISE: begin
          shift_byte_next = '0;
          bit_count_next  = '0;
          push.ev.kind    = EV_ACT;
        end
        OP_DC_FALL: begin
          push.ev.kind = EV_ACT;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_byte <= '0;
      bit_count  <= '0;
    end else begin
      shift_byte <= shift_byte_next;
      bit_count  <= bit_count_next;
    end
  end

endmodule

// ----- sv/svw_queue.sv -----
// ----------------------------------------------------------------------------
// svw_queue
// Short event queue between the front and back parts.
// ----------------------------------------------------------------------------
module svw_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  svw_pkg::queue_push_t push,
  output logic                 full,
  input  logic                 pop,
  output svw_pkg::queue_head_t head
);
  import svw_pkg::*;

  pin_event_t          entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr;
  logic [QUEUE_AW-1:0] rd_ptr;
  logic [QUEUE_AW:0]   count;

  assign full       = (count == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.ev    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.push) begin
      entries[wr_ptr] <= push.ev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push.push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
    else $error("queue count above depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.push |-> !full)
    else $error("push into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head.valid)
    else $error("pop from an empty queue");
`endif

endmodule

// ----- sv/svw_back.sv -----
// ----------------------------------------------------------------------------
// svw_back
// Executes byte and command events: window setup, pixel writes, result register.
// ----------------------------------------------------------------------------
module svw_back #(
  parameter int FRAME_WIDTH  = 480,
  parameter int FRAME_HEIGHT = 320
) (
  input  logic                 clk,
  input  logic                 rst,
  input  svw_pkg::queue_head_t head,
  output logic                 pop,
  svw_out_if.source            frame
);
  import svw_pkg::*;

  localparam logic [WORD_W-1:0] FrameW = WORD_W'(FRAME_WIDTH);
  localparam logic [WORD_W-1:0] FrameH = WORD_W'(FRAME_HEIGHT);

  logic [BYTE_W-1:0] command_code, command_code_next;
  logic [2:0]        data_count, data_count_next;
  logic [BYTE_W-1:0] staged_bytes [4];
  logic              stage_we;
  logic [BYTE_W-1:0] pixel_high;
  logic              pixel_high_we;
  logic              pixel_phase, pixel_phase_next;
  logic [WORD_W-1:0] x_start, x_start_next, x_end, x_end_next;
  logic [WORD_W-1:0] y_start, y_start_next, y_end, y_end_next;
  logic [WORD_W-1:0] x_position, x_position_next, y_position, y_position_next;
  logic              done_flag, done_flag_next;

  logic              take;
  logic              we_c;
  logic [31:0]       row_base;
  logic [ADDR_W-1:0] addr_c;

  logic               out_valid;
  logic               out_we;
  logic [ADDR_W-1:0]  out_addr;
  logic [PIXEL_W-1:0] out_pixel;
  logic               out_ready_flag;

  assign take = head.valid && (!out_valid || frame.ready);
  assign pop  = take;

  assign row_base = 32'(y_position) * 32'(FRAME_WIDTH);
  assign addr_c   = ADDR_W'(row_base + 32'(x_position));

  always_comb begin
    command_code_next = command_code;
    data_count_next   = data_count;
    pixel_phase_next  = pixel_phase;
    x_start_next      = x_start;
    x_end_next        = x_end;
    y_start_next      = y_start;
    y_end_next        = y_end;
    x_position_next   = x_position;
    y_position_next   = y_position;
    done_flag_next    = done_flag;
    stage_we          = 1'b0;
    pixel_high_we     = 1'b0;
    we_c              = 1'b0;
    if (take) begin
      unique case (head.ev.kind)
        EV_BYTE: begin
          if (!head.ev.dc) begin
            command_code_next = head.ev.data;
          end else if (command_code == CMD_MEMORY_WRITE) begin
            if (!pixel_phase) begin
              pixel_high_we    = 1'b1;
              pixel_phase_next = 1'b1;
            end else begin
              pixel_phase_next = 1'b0;
              we_c = (x_position < FrameW) && (y_position < FrameH);
              // step along the row, wrap to the next row at the right edge
              if (x_position >= x_end) begin
                x_position_next = x_start;
                if (y_position != Y_LIMIT) begin
                  y_position_next = y_position + 16'd1;
                end
              end else begin
                x_position_next = x_position + 16'd1;
              end
            end
          end else if (!data_count[2]) begin
            stage_we        = 1'b1;
            data_count_next = data_count + 3'd1;
          end
        end
        EV_ACT: begin
          priority if (command_code == CMD_COLUMN_SET && data_count[2]) begin
            x_start_next    = {staged_bytes[0], staged_bytes[1]};
            x_end_next      = {staged_bytes[2], staged_bytes[3]};
            x_position_next = {staged_bytes[0], staged_bytes[1]};
          end else if (command_code == CMD_ROW_SET && data_count[2]) begin
            y_start_next    = {staged_bytes[0], staged_bytes[1]};
            y_end_next      = {staged_bytes[2], staged_bytes[3]};
            y_position_next = {staged_bytes[0], staged_bytes[1]};
          end else if (command_code == CMD_MEMORY_WRITE) begin
            if (y_position >= y_end && x_position >= x_end) begin
              done_flag_next = 1'b1;
            end
          end else begin
          end
          data_count_next  = '0;
          pixel_phase_next = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (stage_we) begin
      staged_bytes[data_count[1:0]] <= head.ev.data;
    end
    if (pixel_high_we) begin
      pixel_high <= head.ev.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      command_code <= '0;
      data_count   <= '0;
      pixel_phase  <= 1'b0;
      x_start      <= '0;
      x_end        <= '0;
      y_start      <= '0;
      y_end        <= '0;
      x_position   <= '0;
      y_position   <= '0;
      done_flag    <= 1'b0;
    end else begin
      command_code <= command_code_next;
      data_count   <= data_count_next;
      pixel_phase  <= pixel_phase_next;
      x_start      <= x_start_next;
      x_end        <= x_end_next;
      y_start      <= y_start_next;
      y_end        <= y_end_next;
      x_position   <= x_position_next;
      y_position   <= y_position_next;
      done_flag    <= done_flag_next;
    end
  end

  // Result register: load a new transaction whenever the slot is free
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || frame.ready) begin
      out_valid <= take;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_we         <= we_c;
      out_addr       <= we_c ? addr_c : '0;
      out_pixel      <= we_c ? {pixel_high, head.ev.data} : '0;
      out_ready_flag <= done_flag_next;
    end
  end

  assign frame.valid         = out_valid;
  assign frame.write_enable  = out_we;
  assign frame.write_address = out_addr;
  assign frame.pixel_value   = out_pixel;
  assign frame.frame_ready   = out_ready_flag;

`ifndef ASSERT_OFF
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    done_flag |=> done_flag)
    else $error("done flag dropped");
  a_stage_bound: assert property (@(posedge clk) disable iff (rst)
    data_count <= 3'd4)
    else $error("staged byte count above four");
`endif

endmodule

// ----- sv/spi_display_window_writer_top.sv -----
// ----------------------------------------------------------------------------
// spi_display_window_writer_top
// Display-side SPI decoder that turns window and memory-write traffic into
// frame memory writes.
// ----------------------------------------------------------------------------
// Each pin event gives exactly one result transaction. The block takes one event
// per clock cycle and returns one result per cycle while the sink keeps up; each
// event is registered in the queue and its result in the result register before
// the sink sees it. That rate is set by the back part, which updates the window
// and position registers and forms the write address (one multiply by the frame
// width and one add) for each event taken. A two-entry queue between the byte
// assembler and the back part, plus the result register, lets either side stall
// without losing events.
module spi_display_window_writer_top #(
  parameter int FRAME_WIDTH  = 480,
  parameter int FRAME_HEIGHT = 320
) (
  input logic       clk,
  input logic       rst,
  svw_in_if.sink    pin,
  svw_out_if.source frame
);
  import svw_pkg::*;

  queue_push_t push;
  queue_head_t head;
  logic        queue_full;
  logic        pop;

  svw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pin        (pin),
    .queue_full (queue_full),
    .push       (push)
  );

  svw_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (queue_full),
    .pop  (pop),
    .head (head)
  );

  svw_back #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_back (
    .clk   (clk),
    .rst   (rst),
    .head  (head),
    .pop   (pop),
    .frame (frame)
  );

endmodule
